// File: rtl/spcp_pkg.sv
// ----------------------------------------------------------------------------
// spcp_pkg
// Shared types and constants for the segment pair closest points pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package spcp_pkg;

  // fixed-point formats
  localparam int COORD_FRAC_BITS = 16;
  localparam int PARAM_FRAC_BITS = 24;

  // field and datapath widths
  localparam int COORD_W  = 32;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int DOT_W    = PROD_W + 2;
  localparam int WIDE_W   = 2 * DOT_W;
  localparam int GAP_W    = 33;
  localparam int SUMSQ_W  = PROD_W + 2;
  localparam int THRESH_W = 32;

  // multiplier slicing and latency
  localparam int CHUNK_W = 32;
  localparam int MUL_LAT = 5;

  // configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic [APB_ADDR_W-3:0] REG_PARALLEL_THRESHOLD = '0;
  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 32'd43;

  // input word: two segments
  typedef struct packed {
    logic signed [COORD_W-1:0] first_start_x;
    logic signed [COORD_W-1:0] first_start_y;
    logic signed [COORD_W-1:0] first_start_z;
    logic signed [COORD_W-1:0] first_end_x;
    logic signed [COORD_W-1:0] first_end_y;
    logic signed [COORD_W-1:0] first_end_z;
    logic signed [COORD_W-1:0] second_start_x;
    logic signed [COORD_W-1:0] second_start_y;
    logic signed [COORD_W-1:0] second_start_z;
    logic signed [COORD_W-1:0] second_end_x;
    logic signed [COORD_W-1:0] second_end_y;
    logic signed [COORD_W-1:0] second_end_z;
  } pair_t;

  // result word: closest points, gap and flag
  typedef struct packed {
    logic signed [COORD_W-1:0] near_first_x;
    logic signed [COORD_W-1:0] near_first_y;
    logic signed [COORD_W-1:0] near_first_z;
    logic signed [COORD_W-1:0] near_second_x;
    logic signed [COORD_W-1:0] near_second_y;
    logic signed [COORD_W-1:0] near_second_z;
    logic [GAP_W-1:0]          gap_length;
    logic                      degenerate;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/spcp_delay.sv
// ----------------------------------------------------------------------------
// spcp_delay
// Shift line that carries side data alongside the pipeline, with enable.
// ----------------------------------------------------------------------------
`default_nettype none

module spcp_delay #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  wire logic         clk,
  input  wire logic         ce,
  input  wire logic [W-1:0] din,
  output logic      [W-1:0] dout
);

  logic [W-1:0] taps [N];

  // shift on every advance
  always_ff @(posedge clk) begin
    if (ce) begin
      taps[0] <= din;
      for (int k = 1; k < N; k++) begin
        taps[k] <= taps[k-1];
      end
    end
  end

  assign dout = taps[N-1];

endmodule

`default_nettype wire

// File: rtl/spcp_mul.sv
// ----------------------------------------------------------------------------
// spcp_mul
// Pipelined wide signed multiplier built from 32x32 partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module spcp_mul #(
  parameter int WA = 68,
  parameter int WB = 68
) (
  input  wire logic                 clk,
  input  wire logic                 ce,
  input  wire logic signed [WA-1:0] a,
  input  wire logic signed [WB-1:0] b,
  output logic signed [WA+WB-1:0]   p
);

  localparam int CW  = spcp_pkg::CHUNK_W;
  localparam int NA  = (WA + CW - 1) / CW;
  localparam int NB  = (WB + CW - 1) / CW;
  localparam int RWD = (NB + 1) * CW;
  localparam int TW  = (NA + NB) * CW;
  localparam int PW  = WA + WB;

  logic [WA-1:0]     abs_a;
  logic [WB-1:0]     abs_b;
  logic [NA*CW-1:0]  mag_a;
  logic [NB*CW-1:0]  mag_b;
  logic [2*CW-1:0]   pp [NA][NB];
  logic [RWD-1:0]    row_next [NA];
  logic [RWD-1:0]    row [NA];
  logic [TW-1:0]     total_next;
  logic [TW-1:0]     total;
  logic              neg1, neg2, neg3, neg4;

  // magnitudes
  assign abs_a = a[WA-1] ? WA'(-a) : WA'(a);
  assign abs_b = b[WB-1] ? WB'(-b) : WB'(b);

  // row sums of partial products
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_next[i] = row_next[i] + (RWD'(pp[i][j]) << (j * CW));
      end
    end
  end

  // sum of rows
  always_comb begin
    total_next = '0;
    for (int i = 0; i < NA; i++) begin
      total_next = total_next + (TW'(row[i]) << (i * CW));
    end
  end

  // five register stages
  always_ff @(posedge clk) begin
    if (ce) begin
      mag_a <= (NA*CW)'(abs_a);
      mag_b <= (NB*CW)'(abs_b);
      neg1  <= a[WA-1] ^ b[WB-1];
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= mag_a[i*CW +: CW] * mag_b[j*CW +: CW];
        end
      end
      neg2 <= neg1;
      row  <= row_next;
      neg3 <= neg2;
      total <= total_next;
      neg4  <= neg3;
      p <= neg4 ? PW'(-total[PW-1:0]) : total[PW-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/spcp_div.sv
// ----------------------------------------------------------------------------
// spcp_div
// Pipelined restoring divider, one quotient bit a stage, result clamped to
// the range zero to one.
// ----------------------------------------------------------------------------
`default_nettype none

module spcp_div #(
  parameter int DW = 136,
  parameter int PF = 24
) (
  input  wire logic                 clk,
  input  wire logic                 ce,
  input  wire logic signed [DW-1:0] num,
  input  wire logic signed [DW-1:0] den,
  output logic [PF:0]               q
);

  logic [DW-1:0] rem_r   [PF+1];
  logic [DW-1:0] den_r   [PF+1];
  logic [PF-1:0] quo_r   [PF+1];
  logic          zero_r  [PF+1];
  logic          one_r   [PF+1];
  logic [DW-1:0] shifted [PF+1];
  logic          ge      [PF+1];

  // trial subtract per stage
  always_comb begin
    shifted[0] = '0;
    ge[0]      = 1'b0;
    for (int k = 1; k <= PF; k++) begin
      shifted[k] = {rem_r[k-1][DW-2:0], 1'b0};
      ge[k]      = shifted[k] >= den_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      // entry stage: clamp checks
      rem_r[0]  <= num;
      den_r[0]  <= den;
      quo_r[0]  <= '0;
      zero_r[0] <= num[DW-1] | (num == '0);
      one_r[0]  <= num >= den;
      // one quotient bit a stage
      for (int k = 1; k <= PF; k++) begin
        rem_r[k]  <= ge[k] ? shifted[k] - den_r[k-1] : shifted[k];
        den_r[k]  <= den_r[k-1];
        quo_r[k]  <= {quo_r[k-1][PF-2:0], ge[k]};
        zero_r[k] <= zero_r[k-1];
        one_r[k]  <= one_r[k-1];
      end
    end
  end

  // clamp to [0, 1]
  always_comb begin
    if (zero_r[PF]) begin
      q = '0;
    end else if (one_r[PF]) begin
      q = {1'b1, {PF{1'b0}}};
    end else begin
      q = {1'b0, quo_r[PF]};
    end
  end

endmodule

`default_nettype wire

// File: rtl/spcp_sqrt.sv
// ----------------------------------------------------------------------------
// spcp_sqrt
// Pipelined integer square root, one root bit a stage, floor result.
// ----------------------------------------------------------------------------
`default_nettype none

module spcp_sqrt #(
  parameter int SW = 68,
  parameter int RW = 33
) (
  input  wire logic          clk,
  input  wire logic          ce,
  input  wire logic [SW-1:0] sum,
  output logic      [RW-1:0] root
);

  localparam int XW = (SW > 2 * RW) ? SW + 1 : 2 * RW + 1;

  logic [RW-1:0] root_r  [RW];
  logic [XW-1:0] sq_r    [RW];
  logic [SW-1:0] sum_r   [RW];
  logic [RW-1:0] proot   [RW];
  logic [XW-1:0] psq     [RW];
  logic [SW-1:0] psum    [RW];
  logic [XW-1:0] cand_sq [RW];
  logic          take    [RW];

  // candidate square from running square: (r + 2^i)^2 = r^2 + r*2^(i+1) + 4^i
  always_comb begin
    for (int k = 0; k < RW; k++) begin
      if (k == 0) begin
        proot[k] = '0;
        psq[k]   = '0;
        psum[k]  = sum;
      end else begin
        proot[k] = root_r[k-1];
        psq[k]   = sq_r[k-1];
        psum[k]  = sum_r[k-1];
      end
      cand_sq[k] = psq[k] + (XW'(proot[k]) << (RW - k)) + (XW'(1) << (2 * (RW - 1 - k)));
      take[k]    = cand_sq[k] <= XW'(psum[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < RW; k++) begin
        root_r[k] <= take[k] ? (proot[k] | (RW'(1) << (RW - 1 - k))) : proot[k];
        sq_r[k]   <= take[k] ? cand_sq[k] : psq[k];
        sum_r[k]  <= psum[k];
      end
    end
  end

  assign root = root_r[RW-1];

endmodule

`default_nettype wire

// File: rtl/segment_pair_closest_points_core.sv
// ----------------------------------------------------------------------------
// segment_pair_closest_points_core
// Closest points of two 3D segments and the gap between them, pipelined.
//
//   port group   dir   handshake                 word
//   pair         in    pair_valid / pair_ready   spcp_pkg::pair_t
//   result       out   result_valid/result_ready spcp_pkg::result_t
//   apb          in    psel/penable/pready       parallel_threshold at 0x0
//
// One pair enters every cycle while the pipeline advances; the depth is set
// by the divider's one quotient bit per stage and the 33 root-bit stages of
// the square root.
// Reset clears the valid bits and loads the threshold with 43.
// When a result waits untaken, every stage holds and pair_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_pair_closest_points_core #(
  parameter int COORD_FRAC_BITS = spcp_pkg::COORD_FRAC_BITS,
  parameter int PARAM_FRAC_BITS = spcp_pkg::PARAM_FRAC_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              pair_valid,
  output logic                                   pair_ready,
  input  wire spcp_pkg::pair_t                   pair,
  output logic                                   result_valid,
  input  wire logic                              result_ready,
  output spcp_pkg::result_t                      result,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [spcp_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [spcp_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [spcp_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                   pready
);

  localparam int CW     = spcp_pkg::COORD_W;
  localparam int DFW    = spcp_pkg::DIFF_W;
  localparam int PRW    = spcp_pkg::PROD_W;
  localparam int DTW    = spcp_pkg::DOT_W;
  localparam int WW     = spcp_pkg::WIDE_W;
  localparam int P      = PARAM_FRAC_BITS;
  localparam int MW     = P + 2 + DFW;
  localparam int THR_SH = 4 * COORD_FRAC_BITS - 32;
  localparam int SIDE_W = 6 * CW + 6 * DFW;
  localparam int SIDE_N = 10 + P;
  localparam int NEAR_N = 36;
  localparam int DEG_N  = 39 + P;
  localparam int LAT    = 49 + P;

  logic adv;
  logic [LAT-1:0] vld;

  // ---------------- configuration register ----------------
  logic [spcp_pkg::THRESH_W-1:0] threshold;
  logic                          reg_hit;

  assign reg_hit = paddr[spcp_pkg::APB_ADDR_W-1:2] == spcp_pkg::REG_PARALLEL_THRESHOLD;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? threshold : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= spcp_pkg::THRESHOLD_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      threshold <= pwdata;
    end
  end

  // ---------------- flow control ----------------
  assign adv          = ~vld[LAT-1] | result_ready;
  assign pair_ready   = adv;
  assign result_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], pair_valid};
    end
  end

  // ---------------- stage 1: differences ----------------
  logic signed [CW-1:0]  in_p1 [3], in_p2 [3], in_p3 [3], in_p4 [3];
  logic signed [CW-1:0]  p1 [3], p3 [3];
  logic signed [DFW-1:0] u [3], v [3], w [3];

  always_comb begin
    in_p1[0] = pair.first_start_x;  in_p1[1] = pair.first_start_y;
    in_p1[2] = pair.first_start_z;
    in_p2[0] = pair.first_end_x;    in_p2[1] = pair.first_end_y;
    in_p2[2] = pair.first_end_z;
    in_p3[0] = pair.second_start_x; in_p3[1] = pair.second_start_y;
    in_p3[2] = pair.second_start_z;
    in_p4[0] = pair.second_end_x;   in_p4[1] = pair.second_end_y;
    in_p4[2] = pair.second_end_z;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p1[i] <= in_p1[i];
        p3[i] <= in_p3[i];
        u[i]  <= DFW'(in_p2[i]) - DFW'(in_p1[i]);
        v[i]  <= DFW'(in_p4[i]) - DFW'(in_p3[i]);
        w[i]  <= DFW'(in_p1[i]) - DFW'(in_p3[i]);
      end
    end
  end

  // ---------------- stage 2: products ----------------
  logic signed [PRW-1:0] pr_uu [3], pr_uv [3], pr_vv [3], pr_uw [3], pr_vw [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pr_uu[i] <= u[i] * u[i];
        pr_uv[i] <= u[i] * v[i];
        pr_vv[i] <= v[i] * v[i];
        pr_uw[i] <= u[i] * w[i];
        pr_vw[i] <= v[i] * w[i];
      end
    end
  end

  // ---------------- stage 3: dot products ----------------
  logic signed [DTW-1:0] dot_a, dot_b, dot_c, dot_d, dot_e;

  always_ff @(posedge clk) begin
    if (adv) begin
      dot_a <= DTW'(pr_uu[0]) + DTW'(pr_uu[1]) + DTW'(pr_uu[2]);
      dot_b <= DTW'(pr_uv[0]) + DTW'(pr_uv[1]) + DTW'(pr_uv[2]);
      dot_c <= DTW'(pr_vv[0]) + DTW'(pr_vv[1]) + DTW'(pr_vv[2]);
      dot_d <= DTW'(pr_uw[0]) + DTW'(pr_uw[1]) + DTW'(pr_uw[2]);
      dot_e <= DTW'(pr_vw[0]) + DTW'(pr_vw[1]) + DTW'(pr_vw[2]);
    end
  end

  // ---------------- wide products ----------------
  logic signed [WW-1:0] m_ac, m_bb, m_be, m_cd, m_ae, m_bd;

  spcp_mul #(.WA(DTW), .WB(DTW)) u_mul_ac (
    .clk(clk), .ce(adv), .a(dot_a), .b(dot_c), .p(m_ac));
  spcp_mul #(.WA(DTW), .WB(DTW)) u_mul_bb (
    .clk(clk), .ce(adv), .a(dot_b), .b(dot_b), .p(m_bb));
  spcp_mul #(.WA(DTW), .WB(DTW)) u_mul_be (
    .clk(clk), .ce(adv), .a(dot_b), .b(dot_e), .p(m_be));
  spcp_mul #(.WA(DTW), .WB(DTW)) u_mul_cd (
    .clk(clk), .ce(adv), .a(dot_c), .b(dot_d), .p(m_cd));
  spcp_mul #(.WA(DTW), .WB(DTW)) u_mul_ae (
    .clk(clk), .ce(adv), .a(dot_a), .b(dot_e), .p(m_ae));
  spcp_mul #(.WA(DTW), .WB(DTW)) u_mul_bd (
    .clk(clk), .ce(adv), .a(dot_b), .b(dot_d), .p(m_bd));

  // dot products ride along with the multipliers
  logic [4*DTW-1:0] dots_dly;

  spcp_delay #(.W(4*DTW), .N(spcp_pkg::MUL_LAT)) u_dly_dots (
    .clk(clk), .ce(adv), .din({dot_b, dot_c, dot_d, dot_e}), .dout(dots_dly));

  // ---------------- determinant and numerators ----------------
  logic signed [WW-1:0]  det, num_s_raw, num_t_raw;
  logic signed [DTW-1:0] b9, c9, d9, e9;

  always_ff @(posedge clk) begin
    if (adv) begin
      det       <= m_ac - m_bb;
      num_s_raw <= m_be - m_cd;
      num_t_raw <= m_ae - m_bd;
      b9 <= dots_dly[4*DTW-1:3*DTW];
      c9 <= dots_dly[3*DTW-1:2*DTW];
      d9 <= dots_dly[2*DTW-1:DTW];
      e9 <= dots_dly[DTW-1:0];
    end
  end

  // ---------------- parallel test and divider operands ----------------
  logic signed [WW-1:0] thr_wide;
  logic                 is_par, b_gt_c, c_zero;
  logic signed [WW-1:0] num_s, den_s, num_t, den_t;
  logic                 degen10;

  assign thr_wide = $signed(WW'(threshold) << THR_SH);
  assign is_par   = det < thr_wide;
  assign b_gt_c   = b9 > c9;
  assign c_zero   = c9 == '0;

  always_ff @(posedge clk) begin
    if (adv) begin
      num_s <= is_par ? '0 : num_s_raw;
      den_s <= det;
      if (!is_par) begin
        num_t <= num_t_raw;
        den_t <= det;
      end else if (b_gt_c) begin
        num_t <= WW'(d9);
        den_t <= WW'(b9);
      end else if (c_zero) begin
        num_t <= '0;
        den_t <= WW'(c9);
      end else begin
        num_t <= WW'(e9);
        den_t <= WW'(c9);
      end
      degen10 <= is_par & ~b_gt_c & c_zero;
    end
  end

  // ---------------- line parameters ----------------
  logic [P:0] q_s, q_t;

  spcp_div #(.DW(WW), .PF(P)) u_div_s (
    .clk(clk), .ce(adv), .num(num_s), .den(den_s), .q(q_s));
  spcp_div #(.DW(WW), .PF(P)) u_div_t (
    .clk(clk), .ce(adv), .num(num_t), .den(den_t), .q(q_t));

  // segment starts and directions ride along
  logic [SIDE_W-1:0] side_in, side_out;

  assign side_in = {p1[0], p1[1], p1[2], u[0], u[1], u[2],
                    p3[0], p3[1], p3[2], v[0], v[1], v[2]};

  spcp_delay #(.W(SIDE_W), .N(SIDE_N)) u_dly_side (
    .clk(clk), .ce(adv), .din(side_in), .dout(side_out));

  logic signed [CW-1:0]  d_p1 [3], d_p3 [3];
  logic signed [DFW-1:0] d_u [3], d_v [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_p1[i] = side_out[SIDE_W - (i + 1) * CW +: CW];
      d_u[i]  = side_out[SIDE_W - 3 * CW - (i + 1) * DFW +: DFW];
      d_p3[i] = side_out[3 * CW + 3 * DFW - (i + 1) * CW +: CW];
      d_v[i]  = side_out[3 * DFW - (i + 1) * DFW +: DFW];
    end
  end

  // ---------------- points along the segments ----------------
  logic signed [MW-1:0] prod_s [3], prod_t [3];
  logic signed [CW-1:0] a_p1 [3], a_p3 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        prod_s[i] <= MW'($signed({1'b0, q_s})) * MW'(d_u[i]);
        prod_t[i] <= MW'($signed({1'b0, q_t})) * MW'(d_v[i]);
        a_p1[i]   <= d_p1[i];
        a_p3[i]   <= d_p3[i];
      end
    end
  end

  // round half up, drop fraction, add start
  logic signed [MW-1:0] off_s [3], off_t [3];
  logic signed [CW-1:0] n1 [3], n2 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      off_s[i] = (prod_s[i] + (MW'(1) << (P - 1))) >>> P;
      off_t[i] = (prod_t[i] + (MW'(1) << (P - 1))) >>> P;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        n1[i] <= CW'(off_s[i] + MW'(a_p1[i]));
        n2[i] <= CW'(off_t[i] + MW'(a_p3[i]));
      end
    end
  end

  // ---------------- gap length ----------------
  logic signed [DFW-1:0]           gd [3];
  logic signed [PRW-1:0]           gsq [3];
  logic [spcp_pkg::SUMSQ_W-1:0]    sumsq;
  logic [spcp_pkg::GAP_W-1:0]      root;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        gd[i]  <= DFW'(n1[i]) - DFW'(n2[i]);
        gsq[i] <= gd[i] * gd[i];
      end
      sumsq <= spcp_pkg::SUMSQ_W'(gsq[0]) + spcp_pkg::SUMSQ_W'(gsq[1])
             + spcp_pkg::SUMSQ_W'(gsq[2]);
    end
  end

  spcp_sqrt #(.SW(spcp_pkg::SUMSQ_W), .RW(spcp_pkg::GAP_W)) u_sqrt (
    .clk(clk), .ce(adv), .sum(sumsq), .root(root));

  // closest points and flag wait for the root
  logic [6*CW-1:0] near_out;
  logic            degen_out;

  spcp_delay #(.W(6*CW), .N(NEAR_N)) u_dly_near (
    .clk(clk), .ce(adv),
    .din({n1[0], n1[1], n1[2], n2[0], n2[1], n2[2]}), .dout(near_out));

  spcp_delay #(.W(1), .N(DEG_N)) u_dly_degen (
    .clk(clk), .ce(adv), .din(degen10), .dout(degen_out));

  // ---------------- result word ----------------
  always_comb begin
    result.near_first_x  = near_out[6*CW-1:5*CW];
    result.near_first_y  = near_out[5*CW-1:4*CW];
    result.near_first_z  = near_out[4*CW-1:3*CW];
    result.near_second_x = near_out[3*CW-1:2*CW];
    result.near_second_y = near_out[2*CW-1:CW];
    result.near_second_z = near_out[CW-1:0];
    result.gap_length    = root;
    result.degenerate    = degen_out;
  end

endmodule

`default_nettype wire
